// ===== rtl/core/piqc_pkg.sv =====
// Shared types and constants for the point-in-quadrilateral crossing test.
package piqc_pkg;

  // Coordinate format: signed Q16.16 metres
  localparam int unsigned COORD_W = 32;
  // Difference of two coordinates needs one more bit
  localparam int unsigned DIFF_W = COORD_W + 1;
  // Signed difference times unsigned magnitude (zero-extended)
  localparam int unsigned PROD_W = 2 * DIFF_W + 1;

  // Vertex storage and polygon size
  localparam int unsigned VERTEX_MAX       = 4;
  localparam int unsigned VERTEX_COUNT_DEF = 4;
  localparam int unsigned VIDX_W           = $clog2(VERTEX_MAX);

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5,
    REG_D_X = 3'd6,
    REG_D_Y = 3'd7
  } cfg_reg_t;

  // Per-stage advance strobes shared by the edge lanes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_adv_t;

endpackage

// ===== rtl/core/point_in_quad_crossing_test.sv =====
// Top level of the point-in-quadrilateral even-odd crossing test.
// Tests one point per clock, while the output is not stalled, against the
// polygon held in the vertex registers (a, b, c, d in order, closed back to
// a; vertex d is left out when VERTEX_COUNT is 3). An accepted point is
// loaded into the first of four register stages (edge setup, the
// cross-multiply of each edge, the compare, and the crossing parity that
// feeds the output) and moves one stage on whenever the next can take it.
// All edges run in parallel lanes, so with no stall at the output a new
// point is taken every cycle. The user must write the vertex registers only
// while no point is in flight; the block itself does not enforce this.
module point_in_quad_crossing_test #(
  parameter int unsigned VERTEX_COUNT = piqc_pkg::VERTEX_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port
  input  logic                                  cfg_wr_en,
  input  logic [piqc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [piqc_pkg::COORD_W-1:0]          cfg_data,
  // Point input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [piqc_pkg::COORD_W-1:0]   probe_x,
  input  logic signed [piqc_pkg::COORD_W-1:0]   probe_y,
  // Result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  inside_res
);
  import piqc_pkg::*;

  logic signed [COORD_W-1:0] vx [VERTEX_MAX];
  logic signed [COORD_W-1:0] vy [VERTEX_MAX];

  logic                      v1, v2, v3, v4;
  logic                      adv4;
  pipe_adv_t                 adv;
  logic [VERTEX_COUNT-1:0]   crossing;

  // Vertex register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < VERTEX_MAX; k++) begin
        vx[k] <= '0;
        vy[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_A_X: vx[0] <= cfg_data;
        REG_A_Y: vy[0] <= cfg_data;
        REG_B_X: vx[1] <= cfg_data;
        REG_B_Y: vy[1] <= cfg_data;
        REG_C_X: vx[2] <= cfg_data;
        REG_C_Y: vy[2] <= cfg_data;
        REG_D_X: vx[3] <= cfg_data;
        REG_D_Y: vy[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance a stage when its slot is empty or its beat moves on
  assign adv4     = !v4 || !out_stall;
  assign adv.s3   = !v3 || adv4;
  assign adv.s2   = !v2 || adv.s3;
  assign adv.s1   = !v1 || adv.s2;
  assign in_stall = !adv.s1;

  // Valid bits travel with the beats
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv.s1) v1 <= in_valid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
      if (adv4)   v4 <= v3;
    end
  end

  // One lane per polygon edge, closing back to vertex a
  for (genvar i = 0; i < VERTEX_COUNT; i++) begin : g_edge
    localparam int unsigned J = (i + 1) % VERTEX_COUNT;

    piqc_edge u_edge (
      .clk      (clk),
      .adv      (adv),
      .x1       (vx[i]),
      .y1       (vy[i]),
      .x2       (vx[J]),
      .y2       (vy[J]),
      .px       (probe_x),
      .py       (probe_y),
      .crossing (crossing[i])
    );
  end

  // Stage 4: parity of crossings is the result
  always_ff @(posedge clk) begin
    if (adv4) begin
      inside_res <= ^crossing;
    end
  end

  assign out_valid = v4;

endmodule

// ===== rtl/core/piqc_edge.sv =====
// One polygon edge lane: setup, cross-multiply and compare stages.
module piqc_edge (
  input  logic                                clk,
  input  piqc_pkg::pipe_adv_t                 adv,
  input  logic signed [piqc_pkg::COORD_W-1:0] x1,
  input  logic signed [piqc_pkg::COORD_W-1:0] y1,
  input  logic signed [piqc_pkg::COORD_W-1:0] x2,
  input  logic signed [piqc_pkg::COORD_W-1:0] y2,
  input  logic signed [piqc_pkg::COORD_W-1:0] px,
  input  logic signed [piqc_pkg::COORD_W-1:0] py,
  output logic                                crossing
);
  import piqc_pkg::*;

  // Setup terms
  logic signed [DIFF_W-1:0] dx_c;
  logic signed [DIFF_W-1:0] lhs_c;
  logic signed [DIFF_W-1:0] dyp_c;
  logic signed [DIFF_W-1:0] dy_c;
  logic        [DIFF_W-1:0] ady_c;
  logic        [DIFF_W-1:0] adyp_c;
  logic                     cand_c;

  // Stage 1 registers
  logic                     cand1;
  logic signed [DIFF_W-1:0] dx1;
  logic signed [DIFF_W-1:0] lhs1;
  logic        [DIFF_W-1:0] ady1;
  logic        [DIFF_W-1:0] adyp1;

  // Stage 2 registers
  logic signed [DIFF_W:0]   ady_s;
  logic signed [DIFF_W:0]   adyp_s;
  logic                     cand2;
  logic signed [PROD_W-1:0] pl2;
  logic signed [PROD_W-1:0] pr2;

  // Candidate when exactly one endpoint lies strictly above the probe
  assign cand_c = (y1 > py) != (y2 > py);
  assign dx_c   = DIFF_W'(x2) - DIFF_W'(x1);
  assign lhs_c  = DIFF_W'(px) - DIFF_W'(x1);
  assign dyp_c  = DIFF_W'(py) - DIFF_W'(y1);
  assign dy_c   = DIFF_W'(y2) - DIFF_W'(y1);
  assign ady_c  = dy_c[DIFF_W-1]  ? DIFF_W'(-dy_c)  : DIFF_W'(dy_c);
  assign adyp_c = dyp_c[DIFF_W-1] ? DIFF_W'(-dyp_c) : DIFF_W'(dyp_c);

  // Stage 1: capture edge differences
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      cand1 <= cand_c;
      dx1   <= dx_c;
      lhs1  <= lhs_c;
      ady1  <= ady_c;
      adyp1 <= adyp_c;
    end
  end

  // Stage 2: cross-multiply, px-x1 < dx*|dyp|/|dy| becomes
  // (px-x1)*|dy| < dx*|dyp| since |dy| is positive on a candidate edge
  assign ady_s  = $signed({1'b0, ady1});
  assign adyp_s = $signed({1'b0, adyp1});

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      cand2 <= cand1;
      pl2   <= PROD_W'(lhs1 * ady_s);
      pr2   <= PROD_W'(dx1 * adyp_s);
    end
  end

  // Stage 3: compare
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      crossing <= cand2 && (pl2 < pr2);
    end
  end

endmodule

// ===== rtl/core/piqc_checker.sv =====
// Port-level checks for the crossing-test pipeline, bound to the top level.
module piqc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic inside_res
);

  // Hold a stalled result beat unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inside_res))
    else $error("stalled result beat changed");

  // Drop all beats on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present after reset");

  // Stall the input only when the output is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

  // Deliver an accepted point to the output when nothing holds the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      |=> out_valid)
    else $error("accepted point did not reach the output");

endmodule

bind point_in_quad_crossing_test piqc_checker u_piqc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .inside_res (inside_res)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the point-in-quadrilateral crossing test.
`timescale 1ns / 1ps

module testbench;

  import piqc_pkg::*;

  localparam int N_VERT = VERTEX_COUNT_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX = 20;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_A_X;
  logic [COORD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] probe_x = '0;
  logic signed [COORD_W-1:0] probe_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic inside_res;

  // Shadow copy of the vertex registers
  logic signed [COORD_W-1:0] vert_x [VERTEX_MAX] = '{default: '0};
  logic signed [COORD_W-1:0] vert_y [VERTEX_MAX] = '{default: '0};

  // Predicted inside flags, oldest first
  bit inside_due [$];

  int fail_count = 0;
  int cycle_count = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  point_in_quad_crossing_test #(
    .VERTEX_COUNT(N_VERT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .probe_x(probe_x),
    .probe_y(probe_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .inside_res(inside_res)
  );

  always #6 clk = ~clk;

  // One edge: true when the edge straddles py and the point lies left of
  // its exact intercept (ceiling of the rational offset)
  function automatic bit edge_crosses_ray(input longint x1, input longint y1,
                                          input longint x2, input longint y2,
                                          input longint px, input longint py);
    longint dx, dyp, dy, bound;
    longint unsigned mag_dx, mag_dyp, prod, den, q, r;
    if ((y1 > py) == (y2 > py)) return 1'b0;
    dx = x2 - x1;
    dyp = py - y1;
    dy = y2 - y1;
    mag_dx = (dx < 0) ? -dx : dx;
    mag_dyp = (dyp < 0) ? -dyp : dyp;
    den = (dy < 0) ? -dy : dy;
    prod = mag_dx * mag_dyp;
    q = prod / den;
    r = prod % den;
    if (dx >= 0) bound = longint'(q) + ((r != 0) ? 64'sd1 : 64'sd0);
    else bound = -longint'(q);
    return (px - x1) < bound;
  endfunction

  // Even-odd parity over the closed polygon
  function automatic bit crossing_parity(input logic signed [COORD_W-1:0] px,
                                         input logic signed [COORD_W-1:0] py);
    int n, j;
    bit odd;
    n = N_VERT;
    if (n < 3) n = 3;
    if (n > 4) n = 4;
    odd = 1'b0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 < n) ? i + 1 : 0;
      odd ^= edge_crosses_ray(vert_x[i], vert_y[i], vert_x[j], vert_y[j], px, py);
    end
    return odd;
  endfunction

  // Track register writes and predict each accepted point
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VERTEX_MAX; i++) begin
        vert_x[i] = '0;
        vert_y[i] = '0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_A_X: vert_x[0] = cfg_data;
          REG_A_Y: vert_y[0] = cfg_data;
          REG_B_X: vert_x[1] = cfg_data;
          REG_B_Y: vert_y[1] = cfg_data;
          REG_C_X: vert_x[2] = cfg_data;
          REG_C_Y: vert_y[2] = cfg_data;
          REG_D_X: vert_x[3] = cfg_data;
          REG_D_Y: vert_y[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) inside_due.push_back(crossing_parity(probe_x, probe_y));
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    bit want;
    if (!rst && out_valid && !out_stall) begin
      if (inside_due.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("%0t: unexpected result beat: expected none, actual inside_res=%0b",
                   $time, inside_res);
        fail_count++;
      end else begin
        want = inside_due.pop_front();
        if (inside_res !== want) begin
          if (fail_count < REPORT_MAX)
            $display("%0t: inside_res mismatch: expected %0b, actual %0b",
                     $time, want, inside_res);
          fail_count++;
        end
      end
    end
  end

  // Output backpressure in random bursts
  always begin : stall_gen
    int unsigned hold;
    @(posedge clk);
    if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
      hold = $urandom_range(14, 1);
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Send one point beat, with an optional idle gap before it
  task automatic send_probe(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    probe_x <= x;
    probe_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (inside_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load all four vertices while the block is idle
  task automatic set_polygon(input logic signed [COORD_W-1:0] ax, input logic signed [COORD_W-1:0] ay,
                             input logic signed [COORD_W-1:0] bx, input logic signed [COORD_W-1:0] by,
                             input logic signed [COORD_W-1:0] cx, input logic signed [COORD_W-1:0] cy,
                             input logic signed [COORD_W-1:0] dx, input logic signed [COORD_W-1:0] dy);
    logic [COORD_W-1:0] vals [8];
    vals = '{ax, ay, bx, by, cx, cy, dx, dy};
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Registers at reset: every vertex at the origin
  task automatic test_reset_polygon();
    send_probe(C_MIN, C_MIN);
    send_probe(C_MAX, C_MAX);
    send_probe(32'sd0, 32'sd0);
  endtask

  // Small slanted quad: vertices, edges and intercepts with remainders
  task automatic test_slanted_quad();
    set_polygon(32'sd0, 32'sd0, 32'sd3, 32'sd1, 32'sd1, 32'sd4, -32'sd2, 32'sd2);
    send_probe(32'sd1, 32'sd2);
    send_probe(32'sd0, 32'sd0);
    send_probe(32'sd3, 32'sd1);
    send_probe(32'sd2, 32'sd1);
    send_probe(32'sd5, 32'sd2);
    send_probe(-32'sd5, 32'sd1);
    send_probe(-32'sd2, 32'sd2);
    send_probe(-32'sd1, 32'sd3);
    send_probe(32'sd0, 32'sd3);
  endtask

  // Full-range rectangle and diamond: horizontal edges and widest products
  task automatic test_extreme_corners();
    set_polygon(C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX);
    send_probe(32'sd0, 32'sd0);
    send_probe(C_MIN, 32'sd0);
    send_probe(C_MAX - 1, C_MAX - 1);
    send_probe(C_MIN, C_MIN);
    send_probe(C_MAX, 32'sd0);
    set_polygon(C_MIN, 32'sd0, 32'sd0, C_MIN, C_MAX, 32'sd0, 32'sd0, C_MAX);
    send_probe(32'sd0, 32'sd0);
    send_probe(C_MIN + 1, -32'sd1);
    send_probe(C_MAX, C_MAX);
  endtask

  // Self-intersecting vertex order
  task automatic test_crossed_order();
    set_polygon(32'sd0, 32'sd0, 32'sd4, 32'sd4, 32'sd4, 32'sd0, 32'sd0, 32'sd4);
    send_probe(32'sd1, 32'sd2);
    send_probe(32'sd2, 32'sd1);
    send_probe(32'sd3, 32'sd2);
  endtask

  // Random polygon of one of four shapes
  task automatic random_polygon(input int kind);
    logic signed [COORD_W-1:0] cx, cy;
    logic signed [COORD_W-1:0] p [8];
    logic signed [COORD_W-1:0] r [4];
    cx = $signed($urandom) >>> 2;
    cy = $signed($urandom) >>> 2;
    for (int k = 0; k < 4; k++) r[k] = $urandom_range(1 << 20, 1);
    case (kind)
      0: for (int k = 0; k < 8; k++) p[k] = $urandom;
      1: for (int k = 0; k < 8; k++)
           p[k] = ((k % 2 == 0) ? cx : cy) + $urandom_range(131072, 0) - 32'd65536;
      2: p = '{cx - r[0], cy, cx, cy - r[1], cx + r[2], cy, cx, cy + r[3]};
      default: p = '{cx - r[0], cy - r[2], cx + r[1], cy - r[2],
                     cx + r[1], cy + r[3], cx - r[0], cy + r[3]};
    endcase
    set_polygon(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
  endtask

  // Random point: mostly inside the bounding box, some on vertex lines, some anywhere
  task automatic random_probe();
    longint lo_x, hi_x, lo_y, hi_y;
    int unsigned pick, k;
    logic signed [COORD_W-1:0] px, py;
    lo_x = vert_x[0];
    hi_x = vert_x[0];
    lo_y = vert_y[0];
    hi_y = vert_y[0];
    for (int i = 1; i < N_VERT; i++) begin
      if (vert_x[i] < lo_x) lo_x = vert_x[i];
      if (vert_x[i] > hi_x) hi_x = vert_x[i];
      if (vert_y[i] < lo_y) lo_y = vert_y[i];
      if (vert_y[i] > hi_y) hi_y = vert_y[i];
    end
    px = 32'(lo_x + longint'($urandom_range(32'(hi_x - lo_x), 0)));
    py = 32'(lo_y + longint'($urandom_range(32'(hi_y - lo_y), 0)));
    pick = $urandom_range(99, 0);
    if (pick < 15) begin
      px = $urandom;
      py = $urandom;
    end else if (pick < 35) begin
      k = $urandom_range(N_VERT - 1, 0);
      py = vert_y[k];
      if (pick < 25) px = vert_x[k] + $urandom_range(4, 0) - 32'd2;
    end
    send_probe(px, py);
  endtask

  // Random phases with varied idling; the last phase runs with none
  task automatic test_random_polygons();
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin gap_pct = 30; stall_pct = 30; end
        1: begin gap_pct = 0;  stall_pct = 0;  end
        2: begin gap_pct = 60; stall_pct = 10; end
        3: begin gap_pct = 10; stall_pct = 60; end
        4: begin gap_pct = 30; stall_pct = 30; end
        5: begin gap_pct = 45; stall_pct = 45; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      random_polygon(ph % 4);
      repeat (100) random_probe();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    gap_pct = 20;
    stall_pct = 20;
    test_reset_polygon();
    test_slanted_quad();
    test_extreme_corners();
    test_crossed_order();
    test_random_polygons();
    drain();
    if (fail_count == 0 && inside_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/piqc_pkg.sv
rtl/core/piqc_edge.sv
rtl/core/point_in_quad_crossing_test.sv
rtl/core/piqc_checker.sv
tb/testbench.sv
